// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the column anchor locator RTL.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CAL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition on one edge implies another on the next edge.
`define CAL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cal_pkg.sv =====
// Types and constants of the column anchor locator.
// No dependencies; imported by every module of the block.
package cal_pkg;

  localparam int unsigned OUT_OFFSET_W = 48;
  localparam logic [31:0] MAGIC_VALUE  = 32'h4655_4256;

  localparam logic [1:0] STATUS_FOUND     = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_BAD_MAGIC = 2'd2;

  typedef struct packed {
    logic [63:0] file_word;
    logic        last_word;
  } cal_in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [OUT_OFFSET_W-1:0] anchor_offset;
    logic [63:0]             item_count;
    logic [15:0]             item_bits;
    logic [OUT_OFFSET_W-1:0] data_offset;
  } cal_out_t;

endpackage

// ===== rtl/cal_scan.sv =====
// Word-by-word file walker: input register, header checks, anchor tracking.
// Depends on cal_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cal_scan import cal_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  cal_in_t     in_data_i,
  input  logic [15:0] wanted_id_i,
  input  logic        push_ready_i,
  output logic        push_valid_o,
  output cal_out_t    push_data_o
);

  localparam int unsigned OB = OFFSET_BITS;
  localparam logic [OB-1:0] OMAX = {OB{1'b1}};
  localparam logic [OB-1:0] STEP8 = OB'(8);
  localparam logic [OB-1:0] STEP16 = OB'(16);
  localparam logic [OB-1:0] WP_LIMIT = OMAX - OB'(15);
  localparam int unsigned PROD_W = 64 + 13;

  localparam logic [2:0] PH_MAGIC = 3'd0;
  localparam logic [2:0] PH_ALIGN = 3'd1;
  localparam logic [2:0] PH_SCAN  = 3'd2;
  localparam logic [2:0] PH_COUNT = 3'd3;
  localparam logic [2:0] PH_DRAIN = 3'd4;

  function automatic logic [OB-1:0] sat_add(input logic [OB-1:0] a, input logic [OB-1:0] b);
    logic [OB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[OB] ? OMAX : s[OB-1:0];
  endfunction

  function automatic logic [OB-1:0] round_up(input logic [OB-1:0] x, input logic [5:0] sh);
    logic [63:0]   m64;
    logic [OB-1:0] low;
    m64 = (64'd1 << sh) - 64'd1;
    low = m64[OB-1:0];
    if ((x & low) == '0) return x;
    if ((x | low) == OMAX) return OMAX;
    return (x | low) + OB'(1);
  endfunction

  logic          in_vq, in_vd;
  cal_in_t       in_q;
  logic          fire;
  logic [2:0]    phase_q, phase_d;
  logic [OB-1:0] wp_q, wp_d;
  logic [5:0]    shift_q, shift_d;
  logic [OB-1:0] anc_q, anc_d;
  logic [15:0]   width_q, width_d;
  logic          match_q, match_d;
  logic [OB-1:0] na_q, na_d;
  logic          pend_q, pend_d;
  logic          quick_q, quick_d;
  logic [OB-1:0] sum_q, sum_d;
  logic [OB-1:0] data_q, data_d;
  logic [OB-1:0] prod_q, prod_d;

  logic [63:0]     w;
  logic [12:0]     bytes;
  logic [PROD_W-1:0] prod_full;
  logic [OB-1:0]   na_eff;
  logic            hit;
  logic            res_valid;
  cal_out_t        res;

  assign fire       = in_vq && push_ready_i;
  assign in_ready_o = !in_vq || fire;
  assign in_vd      = (in_valid_i && in_ready_o) ? 1'b1 : (fire ? 1'b0 : in_vq);

  assign w         = in_q.file_word;
  assign bytes     = width_q[15:3];
  assign prod_full = PROD_W'(w) * PROD_W'(bytes);
  assign na_eff    = pend_q ? sum_q : na_q;
  assign hit       = (wp_q == na_eff) && (!pend_q || quick_q);

  always_comb begin
    phase_d   = phase_q;
    wp_d      = wp_q;
    shift_d   = shift_q;
    anc_d     = anc_q;
    width_d   = width_q;
    match_d   = match_q;
    na_d      = na_q;
    pend_d    = pend_q;
    quick_d   = quick_q;
    sum_d     = sum_q;
    data_d    = data_q;
    prod_d    = prod_q;
    res_valid = 1'b0;
    res       = '0;
    if (fire) begin
      case (phase_q)
        PH_MAGIC: begin
          if (w[31:0] != MAGIC_VALUE) begin
            res_valid  = 1'b1;
            res.status = STATUS_BAD_MAGIC;
            phase_d    = PH_DRAIN;
          end else begin
            phase_d = PH_ALIGN;
          end
        end
        PH_ALIGN: begin
          shift_d = w[5:0];
          phase_d = PH_SCAN;
        end
        PH_SCAN: begin
          pend_d = 1'b0;
          if (hit) begin
            if (w == 64'd0) begin
              na_d = sat_add(na_eff, STEP8);
            end else begin
              anc_d   = wp_q;
              width_d = w[47:32];
              match_d = (w[31:16] == wanted_id_i);
              sum_d   = sat_add(wp_q, STEP16);
              data_d  = round_up(sat_add(wp_q, STEP16), shift_q);
              phase_d = PH_COUNT;
            end
          end else if (pend_q) begin
            na_d = round_up(sat_add(data_q, prod_q), 6'd3);
          end
        end
        PH_COUNT: begin
          if (match_q) begin
            res_valid         = 1'b1;
            res.status        = STATUS_FOUND;
            res.anchor_offset = OUT_OFFSET_W'(anc_q);
            res.item_count    = w;
            res.item_bits     = width_q;
            res.data_offset   = OUT_OFFSET_W'(data_q);
            phase_d           = PH_DRAIN;
          end else begin
            prod_d  = (|prod_full[PROD_W-1:OB]) ? OMAX : prod_full[OB-1:0];
            quick_d = ((w == 64'd0) || (bytes == 13'd0)) && (data_q == sum_q)
                      && (sum_q != OMAX);
            pend_d  = 1'b1;
            phase_d = PH_SCAN;
          end
        end
        default: begin
        end
      endcase
      if (in_q.last_word) begin
        if (!res_valid && (phase_d != PH_DRAIN)) begin
          res_valid  = 1'b1;
          res        = '0;
          res.status = STATUS_NOT_FOUND;
        end
        phase_d = PH_MAGIC;
        wp_d    = '0;
        shift_d = '0;
        anc_d   = '0;
        width_d = '0;
        match_d = 1'b0;
        na_d    = STEP16;
        pend_d  = 1'b0;
      end else if (wp_q <= WP_LIMIT) begin
        wp_d = wp_q + STEP8;
      end
    end
  end

  assign push_valid_o = res_valid;
  assign push_data_o  = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq   <= 1'b0;
      phase_q <= PH_MAGIC;
      wp_q    <= '0;
      shift_q <= '0;
      anc_q   <= '0;
      width_q <= '0;
      match_q <= 1'b0;
      na_q    <= STEP16;
      pend_q  <= 1'b0;
      quick_q <= 1'b0;
    end else begin
      in_vq   <= in_vd;
      phase_q <= phase_d;
      wp_q    <= wp_d;
      shift_q <= shift_d;
      anc_q   <= anc_d;
      width_q <= width_d;
      match_q <= match_d;
      na_q    <= na_d;
      pend_q  <= pend_d;
      quick_q <= quick_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    sum_q  <= sum_d;
    data_q <= data_d;
    prod_q <= prod_d;
  end

  `CAL_ASSERT(a_push_fire, res_valid |-> fire, "result without a transaction")
  `CAL_ASSERT(a_pend_in_scan, pend_q |-> (phase_q == PH_SCAN), "pending skip outside scan phase")
  `CAL_ASSERT(a_wp_aligned, wp_q[2:0] == 3'd0, "word position lost alignment")
  `CAL_ASSERT_NEXT(a_restart, fire && in_q.last_word, phase_q == PH_MAGIC && wp_q == '0, "no restart")

endmodule

// ===== rtl/cal_skid.sv =====
// Result register with a skid stage for the output channel.
// Depends on cal_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cal_skid import cal_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  cal_out_t push_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output cal_out_t out_data_o
);

  logic     out_valid_q, out_valid_d;
  logic     skid_valid_q, skid_valid_d;
  cal_out_t out_q, out_d;
  cal_out_t skid_q, skid_d;
  logic     pop;

  assign pop          = out_valid_q && out_ready_i;
  assign push_ready_o = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_valid_i) begin
      if (!out_valid_q || pop) begin
        out_d       = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CAL_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid entry without output entry")
  `CAL_ASSERT(a_no_push_full, !(push_valid_i && skid_valid_q), "transaction into full stage")
  `CAL_ASSERT_NEXT(a_out_hold, out_valid_q && !out_ready_i, out_valid_q && $stable(out_q), "not held")

endmodule

// ===== rtl/column_anchor_locator.sv =====
// Column anchor locator: takes a columnar file one 64-bit word per transaction and returns
// one result per file (found column, column not present, or bad magic). Each word is
// registered, handled combinationally against the walker state and, when it closes the search,
// its result lands in a result register backed by a skid stage. A new word is taken every
// cycle while the skid stage is empty; a word's result passes the input register, then the
// result register or skid stage; a full skid stage holds the input until the output is taken.
// The configuration register holds the wanted column id and is written by the user only while
// the block is idle, which is not enforced. Depends on cal_pkg, cal_scan and cal_skid.

module column_anchor_locator import cal_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  cal_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output cal_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] wanted_id_q;
  logic        push_valid;
  logic        push_ready;
  cal_out_t    push_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_id_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      wanted_id_q <= cfg_data_i;
    end
  end

  cal_scan #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .wanted_id_i (wanted_id_q),
    .push_ready_i(push_ready),
    .push_valid_o(push_valid),
    .push_data_o (push_data)
  );

  cal_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
